// ----- rtl/assert_macros.svh -----
// Assertion macros for the checker file of the frame builder.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define AM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, off while reset is low.
`define AM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define AM_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/dssfb_pkg.sv -----
// Shared types, constants and functions of the decimal seven-segment frame builder.
// No dependencies; every module of the block imports it.
package dssfb_pkg;

    localparam int DIGITS  = 5;
    localparam int VALUE_W = 17;
    localparam int BYTE_W  = 8;

    localparam int DIG_CNT_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int FRAME_LEN = DIGITS + 5;
    localparam int IDX_W     = $clog2(FRAME_LEN);

    function automatic longint pow10(input int n);
        longint p;
        p = 1;
        for (int k = 0; k < n; k++) begin
            p = p * 10;
        end
        return p;
    endfunction

    // Largest value shown; anything above saturates to it.
    localparam longint MAX_SHOWN_L = pow10(DIGITS) - 1;
    localparam logic [31:0] MAX_SHOWN = MAX_SHOWN_L[31:0];

    // Divide by ten: q = (x * RECIP_10) >> RECIP_SH, exact for x below 2^18.
    localparam int RECIP_W  = 18;
    localparam int RECIP_SH = 21;
    localparam logic [RECIP_W-1:0] RECIP_10 = RECIP_W'(209716);

    localparam logic [BYTE_W-1:0] CMD_ADDRESS = 8'h08;
    localparam logic [BYTE_W-1:0] CMD_DISPLAY = 8'h18;
    localparam logic [BYTE_W-1:0] CMD_OFF     = 8'h00;
    localparam logic [BYTE_W-1:0] SEG_BLANK   = 8'h00;
    localparam logic [BYTE_W-1:0] CTRL_RESET  = 8'd30;

    // Positions of the address byte and of the bytes after the segment codes.
    localparam logic [IDX_W-1:0] IDX_ADDRESS = IDX_W'(0);
    localparam logic [IDX_W-1:0] IDX_DISP_A  = IDX_W'(DIGITS + 1);
    localparam logic [IDX_W-1:0] IDX_OFF     = IDX_W'(DIGITS + 2);
    localparam logic [IDX_W-1:0] IDX_DISP_B  = IDX_W'(DIGITS + 3);
    localparam logic [IDX_W-1:0] IDX_LAST    = IDX_W'(DIGITS + 4);

    typedef enum logic [1:0] {
        FE_IDLE,
        FE_CONV,
        FE_PUSH
    } t_fe_state;

    // Segment codes of one value, units digit at position 0.
    typedef struct packed {
        logic [DIGITS-1:0][BYTE_W-1:0] seg;
    } t_frame;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [BYTE_W-1:0] seg_code(input logic [3:0] d);
        logic [BYTE_W-1:0] c;
        case (d)
            4'd0:    c = 8'h3f;
            4'd1:    c = 8'h06;
            4'd2:    c = 8'h9b;
            4'd3:    c = 8'h8f;
            4'd4:    c = 8'ha6;
            4'd5:    c = 8'had;
            4'd6:    c = 8'hbd;
            4'd7:    c = 8'h07;
            4'd8:    c = 8'hbf;
            4'd9:    c = 8'haf;
            default: c = SEG_BLANK;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/dssfb_front.sv -----
// Front end: takes values, saturates them and converts to segment codes one digit a cycle.
// Depends on dssfb_pkg; pushes finished frames into dssfb_queue.
module dssfb_front import dssfb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_push,
    output t_frame             o_frame,
    input  t_q_stat            i_q_stat
);

    localparam int PROD_W = VALUE_W + RECIP_W;

    t_fe_state r_state, n_state;
    logic [DIG_CNT_W-1:0] r_cnt, n_cnt;
    logic [VALUE_W-1:0]   r_tmp;
    t_frame               r_frame;

    logic               w_accept;
    logic               w_pushed;
    logic [VALUE_W-1:0] w_sat;
    logic [PROD_W-1:0]  w_prod;
    logic [VALUE_W-1:0] w_quot;
    logic [VALUE_W-1:0] w_rem;
    logic [BYTE_W-1:0]  w_code;

    assign w_pushed = (r_state == FE_PUSH) && !i_q_stat.full;
    assign o_stall  = !((r_state == FE_IDLE) || w_pushed);
    assign w_accept = i_valid && !o_stall;
    assign o_push   = (r_state == FE_PUSH);
    assign o_frame  = r_frame;

    assign w_sat  = (32'(i_value) > MAX_SHOWN) ? MAX_SHOWN[VALUE_W-1:0] : i_value;
    assign w_prod = PROD_W'(r_tmp) * PROD_W'(RECIP_10);
    assign w_quot = VALUE_W'(w_prod[PROD_W-1:RECIP_SH]);
    assign w_rem  = r_tmp - ((w_quot << 3) + (w_quot << 1));
    // Blank a position once no higher-order value remains, except the units digit.
    assign w_code = ((r_cnt != '0) && (r_tmp == '0)) ? SEG_BLANK : seg_code(w_rem[3:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FE_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_tmp <= w_sat;
        end else if (r_state == FE_CONV) begin
            r_tmp <= w_quot;
        end
        if (r_state == FE_CONV) begin
            r_frame.seg[r_cnt] <= w_code;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            FE_IDLE: begin
                if (w_accept) begin
                    n_state = FE_CONV;
                    n_cnt   = '0;
                end
            end
            FE_CONV: begin
                if (r_cnt == DIG_CNT_W'(DIGITS - 1)) begin
                    n_state = FE_PUSH;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            FE_PUSH: begin
                if (w_accept) begin
                    n_state = FE_CONV;
                    n_cnt   = '0;
                end else if (w_pushed) begin
                    n_state = FE_IDLE;
                end
            end
            default: begin
                n_state = FE_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/dssfb_queue.sv -----
// Two-entry frame queue between the converter and the byte sequencer.
// Depends on dssfb_pkg for the frame and status types.
module dssfb_queue import dssfb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_frame  i_frame,
    input  logic    i_pop,
    output t_frame  o_frame,
    output t_q_stat o_stat
);

    t_frame     r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic w_wr;
    logic w_rd;

    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);
    assign w_wr    = i_push && !o_stat.full;
    assign w_rd    = i_pop && !o_stat.empty;
    assign o_frame = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_rd) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

endmodule

// ----- rtl/dssfb_back.sv -----
// Back end: walks the queued frame and drives one byte per beat through an output register.
// Depends on dssfb_pkg; reads frames from dssfb_queue.
module dssfb_back import dssfb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_frame            i_frame,
    input  t_q_stat           i_q_stat,
    output logic              o_pop,
    input  logic [BYTE_W-1:0] i_display_control,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [BYTE_W-1:0] o_tx_byte,
    output logic              o_last
);

    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_valid, n_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;

    logic              w_advance;
    logic              w_load;
    logic [IDX_W-1:0]  w_seg_pos;
    logic [BYTE_W-1:0] w_byte;

    assign w_advance = !r_valid || !i_stall;
    assign w_load    = w_advance && !i_q_stat.empty;
    assign o_pop     = w_load && (r_idx == IDX_LAST);
    assign w_seg_pos = IDX_W'(DIGITS) - r_idx;

    assign o_valid   = r_valid;
    assign o_tx_byte = r_byte;
    assign o_last    = r_last;

    always_comb begin
        if (r_idx == IDX_ADDRESS) begin
            w_byte = CMD_ADDRESS;
        end else if (r_idx < IDX_DISP_A) begin
            // Most significant digit goes out first.
            w_byte = i_frame.seg[w_seg_pos[DIG_CNT_W-1:0]];
        end else if (r_idx == IDX_DISP_A) begin
            w_byte = CMD_DISPLAY;
        end else if (r_idx == IDX_OFF) begin
            w_byte = CMD_OFF;
        end else if (r_idx == IDX_DISP_B) begin
            w_byte = CMD_DISPLAY;
        end else begin
            w_byte = i_display_control;
        end
    end

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        if (w_advance) begin
            n_valid = !i_q_stat.empty;
        end
        if (w_load) begin
            n_idx = (r_idx == IDX_LAST) ? IDX_ADDRESS : r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= IDX_ADDRESS;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= w_byte;
            r_last <= (r_idx == IDX_LAST);
        end
    end

endmodule

// ----- rtl/decimal_seven_segment_frame_builder.sv -----
// Top level of the decimal seven-segment frame builder.
// Depends on dssfb_pkg, dssfb_front, dssfb_queue and dssfb_back.
//
// Usage:
//   Input channel (i_valid / o_stall / i_value): one beat carries a binary value.
//   Values above 10^DIGITS - 1 saturate to that maximum.
//   Output channel (o_valid / i_stall / o_tx_byte / o_last): each value becomes
//   DIGITS + 5 beats: address command, segment codes (most significant first,
//   leading zeros blanked but the units digit kept), off pair, on pair with the
//   display control byte. o_last marks the final beat.
//   i_display_control_we writes i_display_control into the control register;
//   write it only while no frame is in flight.
// Timing:
//   The converter does one divide-by-ten step per digit, then pushes the frame into
//   the queue once it has room; the byte sequencer reads it from there through its
//   output register and sends one byte per cycle while i_stall is low and the queue
//   holds a frame.
//   A two-frame queue lets the converter run ahead of a stalled receiver; while
//   i_stall is high the current byte holds and the input stalls once the queue fills.
// Reset: clears the queue, both control machines and the output valid; the
//   control register returns to 30.
module decimal_seven_segment_frame_builder import dssfb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [VALUE_W-1:0] i_value,
    input  logic               i_display_control_we,
    input  logic [BYTE_W-1:0]  i_display_control,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [BYTE_W-1:0]  o_tx_byte,
    output logic               o_last
);

    logic [BYTE_W-1:0] r_display_control;

    logic    w_push;
    t_frame  w_push_frame;
    logic    w_pop;
    t_frame  w_head_frame;
    t_q_stat w_q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_control <= CTRL_RESET;
        end else if (i_display_control_we) begin
            r_display_control <= i_display_control;
        end
    end

    dssfb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_value  (i_value),
        .o_push   (w_push),
        .o_frame  (w_push_frame),
        .i_q_stat (w_q_stat)
    );

    dssfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_frame (w_push_frame),
        .i_pop   (w_pop),
        .o_frame (w_head_frame),
        .o_stat  (w_q_stat)
    );

    dssfb_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_frame           (w_head_frame),
        .i_q_stat          (w_q_stat),
        .o_pop             (w_pop),
        .i_display_control (r_display_control),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_tx_byte         (o_tx_byte),
        .o_last            (o_last)
    );

endmodule

// ----- rtl/dssfb_checker.sv -----
// Port-level checks for the frame builder, bound onto the top level.
// Depends on dssfb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dssfb_checker import dssfb_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic [VALUE_W-1:0] i_value,
    input logic               o_valid,
    input logic               i_stall,
    input logic [BYTE_W-1:0]  o_tx_byte,
    input logic               o_last
);

    logic w_out_beat;
    assign w_out_beat = o_valid && !i_stall;

    // A stalled output beat holds its byte and marker.
    `AM_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_tx_byte) && $stable(o_last))

    // Reset drops the output valid.
    `AM_ASSERT_NXT_ALWAYS(a_reset_idle, i_clk, !i_rst_n, !o_valid)

    // A frame, once started, streams without gaps.
    `AM_ASSERT_NXT(a_frame_gapless, i_clk, i_rst_n, w_out_beat && !o_last, o_valid)

    // The beat after a frame ends opens the next frame with the address command.
    `AM_ASSERT_NXT(a_frame_start, i_clk, i_rst_n, w_out_beat && o_last, !o_valid || (o_tx_byte == CMD_ADDRESS))

    // A stalled input beat holds its value.
    `AM_ASSERT_NXT(a_in_hold, i_clk, i_rst_n, i_valid && o_stall, i_valid && $stable(i_value))

endmodule

bind decimal_seven_segment_frame_builder dssfb_checker u_dssfb_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_valid),
    .o_stall   (o_stall),
    .i_value   (i_value),
    .o_valid   (o_valid),
    .i_stall   (i_stall),
    .o_tx_byte (o_tx_byte),
    .o_last    (o_last)
);

// ----- sim/tb_top.sv -----
// Self-checking bench for decimal_seven_segment_frame_builder: random and directed values,
// random input gaps and output stalls, control byte changes while the block is idle.
// Depends on dssfb_pkg and the RTL of the frame builder.
module tb_top;
    import dssfb_pkg::*;

    localparam int      FRAME_BEATS = DIGITS + 5;
    localparam int      SETTLE      = 2 * FRAME_BEATS + 10;
    localparam int      LONG_HOLD   = 400;
    localparam logic [BYTE_W-1:0] ADDR_BYTE  = 8'h08;
    localparam logic [BYTE_W-1:0] DISP_BYTE  = 8'h18;
    localparam logic [BYTE_W-1:0] OFF_BYTE   = 8'h00;
    localparam logic [BYTE_W-1:0] BLANK_BYTE = 8'h00;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_frame_beat;

    logic               i_clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic [VALUE_W-1:0] in_value = '0;
    logic               ctrl_we = 1'b0;
    logic [BYTE_W-1:0]  ctrl_data = '0;
    logic               out_stall = 1'b0;
    logic               idle_on = 1'b1;
    logic               o_stall;
    logic               o_valid;
    logic [BYTE_W-1:0]  o_tx_byte;
    logic               o_last;

    logic [VALUE_W-1:0] pending_values[$];
    t_frame_beat        frame_beats_due[$];
    logic [BYTE_W-1:0]  ctrl_shadow = 8'd30;
    int                 in_gap = 0;
    int                 stall_left = 0;
    int                 hold_left = 0;
    int                 holds_done = 0;
    int                 beats_seen = 0;
    int                 frames_checked = 0;
    int                 fault_count = 0;
    int                 ctrl_writes = 0;

    decimal_seven_segment_frame_builder dut (
        .i_clk                (i_clk),
        .i_rst_n              (rst_n),
        .i_valid              (in_valid),
        .o_stall              (o_stall),
        .i_value              (in_value),
        .i_display_control_we (ctrl_we),
        .i_display_control    (ctrl_data),
        .o_valid              (o_valid),
        .i_stall              (out_stall),
        .o_tx_byte            (o_tx_byte),
        .o_last               (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int decade(input int n);
        int p;
        p = 1;
        repeat (n) p = p * 10;
        return p;
    endfunction

    function automatic logic [BYTE_W-1:0] digit_glyph(input int d);
        logic [BYTE_W-1:0] g;
        case (d)
            0: g = 8'h3f;
            1: g = 8'h06;
            2: g = 8'h9b;
            3: g = 8'h8f;
            4: g = 8'ha6;
            5: g = 8'had;
            6: g = 8'hbd;
            7: g = 8'h07;
            8: g = 8'hbf;
            9: g = 8'haf;
            default: g = BLANK_BYTE;
        endcase
        return g;
    endfunction

    // Mostly short gaps, now and then a long one; none while idling is off.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        int pick;
        int k;
        pick = $urandom_range(0, 99);
        if (pick < 40) return VALUE_W'($urandom_range(0, (1 << VALUE_W) - 1));
        if (pick < 65) begin
            k = $urandom_range(1, DIGITS);
            return VALUE_W'($urandom_range(0, decade(k) - 1));
        end
        if (pick < 80) return VALUE_W'($urandom_range(decade(DIGITS), (1 << VALUE_W) - 1));
        // land around a power of ten, where the blanked width changes
        k = $urandom_range(1, DIGITS);
        return VALUE_W'(decade(k) + $urandom_range(0, 2) - 1);
    endfunction

    // Push the beats that one accepted value must produce.
    task automatic predict_frame(input logic [VALUE_W-1:0] raw);
        int shown;
        int rest;
        int sig;
        int digs[DIGITS];
        logic [BYTE_W-1:0] code;
        shown = raw;
        if (shown > decade(DIGITS) - 1) shown = decade(DIGITS) - 1;
        rest = shown;
        for (int i = DIGITS - 1; i >= 0; i--) begin
            digs[i] = rest % 10;
            rest = rest / 10;
        end
        sig = 0;
        rest = shown;
        while (rest != 0) begin
            rest = rest / 10;
            sig++;
        end
        if (sig == 0) sig = 1;
        frame_beats_due.push_back(t_frame_beat'{ADDR_BYTE, 1'b0});
        for (int i = 0; i < DIGITS; i++) begin
            code = (i < DIGITS - sig) ? BLANK_BYTE : digit_glyph(digs[i]);
            frame_beats_due.push_back(t_frame_beat'{code, 1'b0});
        end
        frame_beats_due.push_back(t_frame_beat'{DISP_BYTE, 1'b0});
        frame_beats_due.push_back(t_frame_beat'{OFF_BYTE, 1'b0});
        frame_beats_due.push_back(t_frame_beat'{DISP_BYTE, 1'b0});
        frame_beats_due.push_back(t_frame_beat'{ctrl_shadow, 1'b1});
    endtask

    // Sender: hold the beat while stalled, then wait out a random gap.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_gap <= 0;
        end else if (!in_valid || !o_stall) begin
            if (in_gap > 0) begin
                in_valid <= 1'b0;
                in_gap <= in_gap - 1;
            end else if (pending_values.size() > 0) begin
                in_valid <= 1'b1;
                in_value <= pending_values.pop_front();
                in_gap <= pick_gap();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus two long hold-offs that back the block up.
    always @(posedge i_clk) begin : receiver
        int gap;
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_left <= 0;
            hold_left <= 0;
            holds_done <= 0;
        end else if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (holds_done < 2 && beats_seen >= ((holds_done == 0) ? 150 : 3300)) begin
            out_stall <= 1'b1;
            hold_left <= LONG_HOLD;
            holds_done <= holds_done + 1;
        end else if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else begin
            gap = pick_gap();
            out_stall <= (gap != 0);
            stall_left <= (gap > 0) ? gap - 1 : 0;
        end
    end

    // Predict on each accepted value, check each accepted output beat.
    always @(posedge i_clk) begin : monitor
        t_frame_beat due;
        if (rst_n) begin
            if (in_valid && !o_stall) predict_frame(in_value);
            if (o_valid && !out_stall) begin
                beats_seen <= beats_seen + 1;
                if (frame_beats_due.size() == 0) begin
                    if (fault_count < 10)
                        $display("ERROR: beat %0d with nothing due: byte %h last %b",
                                 beats_seen, o_tx_byte, o_last);
                    fault_count <= fault_count + 1;
                end else begin
                    due = frame_beats_due.pop_front();
                    if (o_tx_byte !== due.data || o_last !== due.last) begin
                        if (fault_count < 10)
                            $display("ERROR: beat %0d: expected byte %h last %b, got byte %h last %b",
                                     beats_seen, due.data, due.last, o_tx_byte, o_last);
                        fault_count <= fault_count + 1;
                    end
                    if (due.last) frames_checked <= frames_checked + 1;
                end
            end
        end
    end

    task automatic drain_frames();
        while (pending_values.size() != 0 || in_valid || frame_beats_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_control(input logic [BYTE_W-1:0] v);
        @(posedge i_clk);
        ctrl_we <= 1'b1;
        ctrl_data <= v;
        ctrl_shadow = v;
        ctrl_writes++;
        @(posedge i_clk);
        ctrl_we <= 1'b0;
    endtask

    task automatic queue_random(input int n);
        @(negedge i_clk);
        repeat (n) pending_values.push_back(random_value());
    endtask

    initial begin
        logic [VALUE_W-1:0] directed[];
        directed = '{
            0, 1, 9, 10, 99, 100, 999, 1000, 9999, 10000, 99999, 100000, 131071,
            12345, 67890, 10203, 90807, 54321, 86420, 2, 0, 70000, 65535, 99998
        };
        repeat (2) @(posedge i_clk);
        rst_n <= 1'b1;

        // reset control byte, edge values and saturation
        @(negedge i_clk);
        foreach (directed[i]) pending_values.push_back(directed[i]);
        drain_frames();

        write_control(8'h00);
        queue_random(130);
        drain_frames();

        // a stretch without gaps on either side
        write_control(8'hff);
        @(posedge i_clk);
        idle_on <= 1'b0;
        queue_random(130);
        drain_frames();
        @(posedge i_clk);
        idle_on <= 1'b1;

        write_control(BYTE_W'($urandom_range(1, 254)));
        queue_random(120);
        drain_frames();

        write_control(BYTE_W'($urandom_range(0, 255)));
        queue_random(100);
        drain_frames();

        $display("Covered %0d frames (%0d beats) across %0d control settings, with two long receiver hold-offs.",
                 frames_checked, beats_seen, ctrl_writes + 1);
        $display("Mismatches or unexpected beats: %0d", fault_count);
        if (fault_count == 0 && frame_beats_due.size() == 0) begin
            $display("decimal_seven_segment_frame_builder verification clean");
        end else begin
            $display("decimal_seven_segment_frame_builder verification failed");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("Timeout: %0d beats still due", frame_beats_due.size());
        $display("decimal_seven_segment_frame_builder verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/dssfb_pkg.sv
rtl/dssfb_front.sv
rtl/dssfb_queue.sv
rtl/dssfb_back.sv
rtl/decimal_seven_segment_frame_builder.sv
rtl/dssfb_checker.sv
sim/tb_top.sv
